// ===== hw/rtl/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants of the png scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int unsigned MAX_WIDTH   = 16384;
    localparam int unsigned WIDTH_W     = 15;
    localparam int unsigned COL_W       = 17;
    localparam int unsigned STORE_DEPTH = 65536;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ARGB_W      = 32;

    // output queue
    localparam int unsigned FIFO_DEPTH  = 3;
    localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;

    // configuration register indexes
    localparam logic [0:0] CFG_IMAGE_WIDTH = 1'b0;
    localparam logic [0:0] CFG_HAS_ALPHA   = 1'b1;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // one request on its way from the column tracker to reconstruction
    typedef struct packed {
        logic                valid;
        logic                is_filter;
        logic [1:0]          chan;
        logic                first_row;
        t_filter             filter;
        logic                pixel_done;
        logic                row_end;
        logic                has_alpha;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   raw;
    } t_s1_ctl;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   data;
    } t_store_wr;

    typedef struct packed {
        logic [ARGB_W-1:0]   argb;
        logic                row_end;
    } t_result;

endpackage

// ===== hw/rtl/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction (none, sub, up, average, Paeth) to ARGB pixels.
// ----------------------------------------------------------------------------
// Input channel: one inflated byte per request (i_raw_byte), with i_image_start
// marking the filter byte that opens a new image. Each row is a filter byte
// then image_width pixels of 3 (RGB) or 4 (RGBA) bytes. Filter bytes give no
// result; the byte that completes a pixel gives one 32-bit ARGB word with
// o_row_end set on the last pixel of a row, alpha 0xff for RGB.
// Throughput is one byte per clock while o_in_stall is low. The previous row
// sits in a 65536 x 8 line store with one write and one registered read
// port: a byte reads its up neighbour when accepted and its reconstructed
// value is written back the next cycle, so the store port pair sets the
// one-byte-per-clock figure. The completing byte is registered, then its pixel
// enters the three-entry result queue, which raises o_out_valid and absorbs
// output stalls; o_in_stall rises once the queue and the byte in flight could
// fill it, and drops as results drain. Reset clears control state and the
// queue; the block then waits for a filter byte. The line store needs no
// clearing: the first row reads no neighbours. Configuration (i_cfg_we,
// i_cfg_index, i_cfg_data) is written by the user between bytes; not enforced.
// ----------------------------------------------------------------------------
module png_scanline_unfilter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [psu_pkg::WIDTH_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [psu_pkg::BYTE_W-1:0]    i_raw_byte,
    input  logic                          i_image_start,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [psu_pkg::ARGB_W-1:0]    o_pixel_argb,
    output logic                          o_row_end
);

    logic                            accept;
    logic                            rd_en;
    logic [psu_pkg::ADDR_W-1:0]      rd_addr;
    logic [psu_pkg::BYTE_W-1:0]      rd_data;
    psu_pkg::t_s1_ctl                s1;
    psu_pkg::t_store_wr              wr;
    logic                            push;
    psu_pkg::t_result                result;
    psu_pkg::t_result                out_data;
    logic [psu_pkg::FIFO_CNT_W-1:0]  fifo_count;
    logic [psu_pkg::FIFO_CNT_W:0]    fill;

    // queue entries already used plus the byte in reconstruction
    assign fill       = {1'b0, fifo_count} + {{psu_pkg::FIFO_CNT_W{1'b0}}, s1.valid};
    assign o_in_stall = fill > (psu_pkg::FIFO_CNT_W + 1)'(psu_pkg::FIFO_DEPTH - 1);
    assign accept     = i_in_valid && !o_in_stall;

    psu_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_raw_byte    (i_raw_byte),
        .i_image_start (i_image_start),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_s1          (s1)
    );

    psu_line_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    psu_recon u_recon (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_rd_data (rd_data),
        .o_wr      (wr),
        .o_push    (push),
        .o_result  (result)
    );

    psu_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data),
        .o_count (fifo_count)
    );

    assign o_pixel_argb = out_data.argb;
    assign o_row_end    = out_data.row_end;

endmodule

// ===== hw/rtl/psu_line_store.sv =====
// ----------------------------------------------------------------------------
// psu_line_store
// Previous row byte store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module psu_line_store (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [psu_pkg::ADDR_W-1:0]    i_rd_addr,
    output logic [psu_pkg::BYTE_W-1:0]    o_rd_data,
    input  psu_pkg::t_store_wr            i_wr
);

    logic [psu_pkg::BYTE_W-1:0] r_mem [psu_pkg::STORE_DEPTH];
    logic [psu_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/psu_ctrl.sv =====
// ----------------------------------------------------------------------------
// psu_ctrl
// Configuration registers, filter byte decode and byte column tracking.
// ----------------------------------------------------------------------------
module psu_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_index,
    input  logic [psu_pkg::WIDTH_W-1:0]   i_cfg_data,
    input  logic                          i_accept,
    input  logic [psu_pkg::BYTE_W-1:0]    i_raw_byte,
    input  logic                          i_image_start,
    output logic                          o_rd_en,
    output logic [psu_pkg::ADDR_W-1:0]    o_rd_addr,
    output psu_pkg::t_s1_ctl              o_s1
);

    logic [psu_pkg::WIDTH_W-1:0] r_width;
    logic                        r_has_alpha;
    logic [psu_pkg::COL_W-1:0]   r_col;
    logic [1:0]                  r_mod3;
    psu_pkg::t_filter            r_filter;
    logic                        r_await;
    logic                        r_first;
    psu_pkg::t_s1_ctl            r_s1;

    logic [psu_pkg::WIDTH_W-1:0] width_eff;
    logic [psu_pkg::COL_W-1:0]   stride;
    logic [psu_pkg::COL_W-1:0]   n_col;
    logic [1:0]                  n_mod3;
    logic [1:0]                  chan;
    logic                        start_row;
    logic                        row_done;
    psu_pkg::t_filter            dec_filter;

    always_comb begin
        if (r_width == '0) begin
            width_eff = psu_pkg::WIDTH_W'(1);
        end else if (r_width > psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH)) begin
            width_eff = psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH);
        end else begin
            width_eff = r_width;
        end
        if (r_has_alpha) begin
            stride = {width_eff, 2'b00};
        end else begin
            stride = {1'b0, width_eff, 1'b0} + {2'b00, width_eff};
        end
        // channel is column mod bytes per pixel, mod 3 kept by its own counter
        chan      = r_has_alpha ? r_col[1:0] : r_mod3;
        n_col     = r_col + psu_pkg::COL_W'(1);
        n_mod3    = (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
        row_done  = (n_col >= stride);
        start_row = r_await | i_image_start;
        if (i_raw_byte > 8'd4) begin
            dec_filter = psu_pkg::FILT_NONE;
        end else begin
            dec_filter = psu_pkg::t_filter'(i_raw_byte[2:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= psu_pkg::WIDTH_W'(1);
            r_has_alpha <= 1'b0;
            r_col       <= '0;
            r_mod3      <= '0;
            r_filter    <= psu_pkg::FILT_NONE;
            r_await     <= 1'b1;
            r_first     <= 1'b1;
            r_s1        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    psu_pkg::CFG_IMAGE_WIDTH: r_width     <= i_cfg_data;
                    psu_pkg::CFG_HAS_ALPHA:   r_has_alpha <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_s1.valid <= i_accept;
            if (i_accept) begin
                r_s1.raw       <= i_raw_byte;
                r_s1.has_alpha <= r_has_alpha;
                r_s1.addr      <= r_col[psu_pkg::ADDR_W-1:0];
                r_s1.chan      <= chan;
                r_s1.filter    <= r_filter;
                r_s1.first_row <= r_first;
                if (start_row) begin
                    r_s1.is_filter  <= 1'b1;
                    r_s1.pixel_done <= 1'b0;
                    r_s1.row_end    <= 1'b0;
                    r_filter        <= dec_filter;
                    r_col           <= '0;
                    r_mod3          <= '0;
                    r_await         <= 1'b0;
                    if (i_image_start) begin
                        r_first <= 1'b1;
                    end
                end else begin
                    r_s1.is_filter  <= 1'b0;
                    r_s1.pixel_done <= r_has_alpha ? (chan == 2'd3) : (chan == 2'd2);
                    r_s1.row_end    <= row_done;
                    r_col           <= n_col;
                    r_mod3          <= n_mod3;
                    if (row_done) begin
                        r_await <= 1'b1;
                        r_first <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_rd_en   = i_accept && !start_row;
    assign o_rd_addr = r_col[psu_pkg::ADDR_W-1:0];
    assign o_s1      = r_s1;

endmodule

// ===== hw/rtl/psu_recon.sv =====
// ----------------------------------------------------------------------------
// psu_recon
// Byte reconstruction: predictor select, line store write-back, pixel pack.
// ----------------------------------------------------------------------------
module psu_recon (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psu_pkg::t_s1_ctl              i_s1,
    input  logic [psu_pkg::BYTE_W-1:0]    i_rd_data,
    output psu_pkg::t_store_wr            o_wr,
    output logic                          o_push,
    output psu_pkg::t_result              o_result
);

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [8:0]        pa;
        logic [8:0]        pb;
        logic [8:0]        pc;
        logic [7:0]        pick;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa = da[9] ? 9'(-da) : da[8:0];
        pb = db[9] ? 9'(-db) : db[8:0];
        pc = dc[9] ? 9'(-dc) : dc[8:0];
        if (pa <= pb && pa <= pc) begin
            pick = a;
        end else if (pb <= pc) begin
            pick = b;
        end else begin
            pick = c;
        end
        return pick;
    endfunction

    logic [3:0][7:0] r_left;
    logic [3:0][7:0] r_upleft;
    logic [2:0][7:0] r_gather;

    logic [7:0]      a;
    logic [7:0]      b;
    logic [7:0]      c;
    logic [8:0]      sum_ab;
    logic [7:0]      pred;
    logic [7:0]      val;
    logic [2:0][7:0] n_gather;
    logic [7:0]      alpha;
    logic            sample;

    always_comb begin
        sample = i_s1.valid && !i_s1.is_filter;
        a      = r_left[i_s1.chan];
        b      = i_s1.first_row ? 8'd0 : i_rd_data;
        c      = i_s1.first_row ? 8'd0 : r_upleft[i_s1.chan];
        sum_ab = {1'b0, a} + {1'b0, b};
        case (i_s1.filter)
            psu_pkg::FILT_SUB:   pred = a;
            psu_pkg::FILT_UP:    pred = b;
            psu_pkg::FILT_AVG:   pred = sum_ab[8:1];
            psu_pkg::FILT_PAETH: pred = paeth(a, b, c);
            default:             pred = 8'd0;
        endcase
        val      = i_s1.raw + pred;
        n_gather = r_gather;
        if (i_s1.chan != 2'd3) begin
            n_gather[i_s1.chan[1:0]] = val;
        end
        alpha = i_s1.has_alpha ? val : psu_pkg::ALPHA_OPAQUE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_upleft <= '0;
            r_gather <= '0;
        end else if (i_s1.valid) begin
            if (i_s1.is_filter) begin
                r_left   <= '0;
                r_upleft <= '0;
                r_gather <= '0;
            end else begin
                r_left[i_s1.chan]   <= val;
                r_upleft[i_s1.chan] <= b;
                r_gather            <= n_gather;
            end
        end
    end

    assign o_wr.en          = sample;
    assign o_wr.addr        = i_s1.addr;
    assign o_wr.data        = val;
    assign o_push           = sample && i_s1.pixel_done;
    assign o_result.argb    = {alpha, n_gather[0], n_gather[1], n_gather[2]};
    assign o_result.row_end = i_s1.row_end;

endmodule

// ===== hw/rtl/psu_out_fifo.sv =====
// ----------------------------------------------------------------------------
// psu_out_fifo
// Small result queue between reconstruction and the output channel.
// ----------------------------------------------------------------------------
module psu_out_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  psu_pkg::t_result                  i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output psu_pkg::t_result                  o_data,
    output logic [psu_pkg::FIFO_CNT_W-1:0]    o_count
);

    psu_pkg::t_result                r_mem [psu_pkg::FIFO_DEPTH];
    logic [psu_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [psu_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [psu_pkg::FIFO_CNT_W-1:0]  r_count;
    logic                            pop;

    function automatic logic [psu_pkg::FIFO_PTR_W-1:0] ptr_inc(
        input logic [psu_pkg::FIFO_PTR_W-1:0] p);
        logic [psu_pkg::FIFO_PTR_W-1:0] q;
        if (p == psu_pkg::FIFO_PTR_W'(psu_pkg::FIFO_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + psu_pkg::FIFO_PTR_W'(1);
        end
        return q;
    endfunction

    assign pop = (r_count != '0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + psu_pkg::FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - psu_pkg::FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== hw/rtl/psu_checker.sv =====
// ----------------------------------------------------------------------------
// psu_checker
// Port level checks of the png scanline unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module psu_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [psu_pkg::ARGB_W-1:0]    o_pixel_argb,
    input  logic                          o_row_end
);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_pixel_argb) && $stable(o_row_end))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    // a fresh result needs an accepted byte behind it, through the reconstruction register and the queue
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without an accepted byte");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);

// ===== bench/tb_png_scanline_unfilter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter
// Self-checking bench for the scanline unfilter. Bytes go in one request at a
// time with random gaps and output stalls. A software copy of the filter
// reconstruction predicts every ARGB word, and each result is compared with it.
// Runs cover all filters, RGB and RGBA, widths from zero to above the
// maximum, image restarts part-way through a row and width changes on a row.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned PHASE_BYTES    = 90;
    localparam int unsigned WIDE_SAMPLES   = 40;
    localparam int unsigned MAX_REPORTS    = 30;

    // software copy of the reconstruction, with the pixels still owed by the block
    class unfilter_tracker;
        bit [psu_pkg::BYTE_W-1:0]  line_store [psu_pkg::STORE_DEPTH];
        bit [31:0]                 left_w;
        bit [31:0]                 upleft_w;
        bit [psu_pkg::COL_W-1:0]   col;
        psu_pkg::t_filter          filt;
        bit                        awaiting_filter;
        bit                        first_row;
        bit [23:0]                 gather;
        bit [psu_pkg::WIDTH_W-1:0] width_reg;
        bit                        alpha_reg;
        int unsigned               store_extent;
        psu_pkg::t_result          due_pixels[$];
        int unsigned               n_requests;
        int unsigned               n_pixels;
        int unsigned               n_row_ends;
        int unsigned               n_errors;
        int unsigned               n_settings;
        int unsigned               filter_count[6];

        function void clear();
            left_w          = '0;
            upleft_w        = '0;
            col             = '0;
            filt            = psu_pkg::FILT_NONE;
            awaiting_filter = 1'b1;
            first_row       = 1'b1;
            gather          = '0;
            width_reg       = 15'd1;
            alpha_reg       = 1'b0;
            store_extent    = 0;
            due_pixels.delete();
        endfunction

        function int unsigned pixel_bytes();
            return alpha_reg ? 4 : 3;
        endfunction

        function int unsigned row_bytes();
            int unsigned w;
            w = width_reg;
            if (w == 0) w = 1;
            if (w > psu_pkg::MAX_WIDTH) w = psu_pkg::MAX_WIDTH;
            return w * pixel_bytes();
        endfunction

        function void write_reg(logic [0:0] idx, bit [psu_pkg::WIDTH_W-1:0] data);
            if (idx == psu_pkg::CFG_IMAGE_WIDTH) width_reg = data;
            else alpha_reg = data[0];
        endfunction

        function bit [7:0] paeth(bit [7:0] a, bit [7:0] b, bit [7:0] c);
            int p, pa, pb, pc;
            p  = int'(a) + int'(b) - int'(c);
            pa = p - int'(a);
            pb = p - int'(b);
            pc = p - int'(c);
            if (pa < 0) pa = -pa;
            if (pb < 0) pb = -pb;
            if (pc < 0) pc = -pc;
            if (pa <= pb && pa <= pc) return a;
            return (pb <= pc) ? b : c;
        endfunction

        function void take_byte(bit [7:0] raw, bit start);
            int unsigned      stride, k, addr;
            bit [7:0]         a, b, c, pred, val;
            bit [8:0]         sum;
            psu_pkg::t_result res;
            n_requests++;
            stride = row_bytes();
            if (start) begin
                first_row       = 1'b1;
                awaiting_filter = 1'b1;
            end
            if (awaiting_filter) begin
                filt = (raw > 8'd4) ? psu_pkg::FILT_NONE : psu_pkg::t_filter'(raw[2:0]);
                filter_count[(raw > 8'd4) ? 5 : raw]++;
                col             = '0;
                left_w          = '0;
                upleft_w        = '0;
                gather          = '0;
                awaiting_filter = 1'b0;
                return;
            end
            k    = col % pixel_bytes();
            addr = col[psu_pkg::ADDR_W-1:0];
            a    = left_w[8*k +: 8];
            b    = first_row ? 8'd0 : line_store[addr];
            c    = first_row ? 8'd0 : upleft_w[8*k +: 8];
            sum  = a + b;
            case (filt)
                psu_pkg::FILT_SUB:   pred = a;
                psu_pkg::FILT_UP:    pred = b;
                psu_pkg::FILT_AVG:   pred = sum[8:1];
                psu_pkg::FILT_PAETH: pred = paeth(a, b, c);
                default:             pred = 8'd0;
            endcase
            val = raw + pred;
            left_w[8*k +: 8]   = val;
            upleft_w[8*k +: 8] = b;
            line_store[addr]   = val;
            if (addr + 1 > store_extent) store_extent = addr + 1;
            if (k < 3) gather[8*k +: 8] = val;
            col = col + 1'b1;
            if (k == pixel_bytes() - 1) begin
                res.argb    = {alpha_reg ? val : psu_pkg::ALPHA_OPAQUE,
                               gather[7:0], gather[15:8], gather[23:16]};
                res.row_end = (col >= stride);
                due_pixels.push_back(res);
            end
            if (col >= stride) begin
                awaiting_filter = 1'b1;
                first_row       = 1'b0;
            end
        endfunction

        function bit count_error();
            n_errors++;
            return n_errors <= MAX_REPORTS;
        endfunction

        function void check_pixel(logic [psu_pkg::ARGB_W-1:0] argb, logic row_end);
            psu_pkg::t_result want;
            if (due_pixels.size() == 0) begin
                if (count_error())
                    $display("%0t: pixel %h row_end %b with none due", $time, argb, row_end);
                return;
            end
            want = due_pixels.pop_front();
            n_pixels++;
            if (want.row_end) n_row_ends++;
            if (argb !== want.argb && count_error())
                $display("%0t: pixel %0d argb expected %h, got %h",
                         $time, n_pixels, want.argb, argb);
            if (row_end !== want.row_end && count_error())
                $display("%0t: pixel %0d row_end expected %b, got %b",
                         $time, n_pixels, want.row_end, row_end);
        endfunction
    endclass

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_we      = 1'b0;
    logic [0:0]                    i_cfg_index   = '0;
    logic [psu_pkg::WIDTH_W-1:0]   i_cfg_data    = '0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_stall;
    logic [psu_pkg::BYTE_W-1:0]    i_raw_byte    = '0;
    logic                          i_image_start = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall   = 1'b0;
    logic [psu_pkg::ARGB_W-1:0]    o_pixel_argb;
    logic                          o_row_end;

    unfilter_tracker      sb;
    bit                   light_idle;
    int unsigned          no_gap_left;
    int unsigned          stall_left;
    bit                   was_stalled;
    int unsigned          quiet_cycles;

    // {image_start, byte}: one short row per filter, then an out-of-range filter
    bit [8:0] directed_seq [24] = '{
        9'h100, 9'h000, 9'h0ff, 9'h080,
        9'h001, 9'h0ff, 9'h001, 9'h07f,
        9'h002, 9'h001, 9'h0ff, 9'h080,
        9'h003, 9'h0ff, 9'h000, 9'h001,
        9'h004, 9'h080, 9'h07f, 9'h0ff,
        9'h0ff, 9'h012, 9'h034, 9'h056
    };

    int unsigned phase_width [11] = '{1, 0, 2, 3, 5, 4, 7, 12, 6, 1, 3};

    png_scanline_unfilter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_raw_byte    (i_raw_byte),
        .i_image_start (i_image_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_argb  (o_pixel_argb),
        .o_row_end     (o_row_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // output side: random stall and free runs, never two stall runs in a row
    always @(posedge i_clk) begin : out_side
        int unsigned r, r2;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
            was_stalled = 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
        end else begin
            r  = $urandom_range(0, 99);
            r2 = $urandom_range(0, 99);
            if (was_stalled || r >= (light_idle ? 5 : 40)) begin
                i_out_stall <= 1'b0;
                was_stalled = 1'b0;
                stall_left  = (r2 < 8) ? $urandom_range(20, 120) : $urandom_range(0, 5);
            end else begin
                i_out_stall <= 1'b1;
                was_stalled = 1'b1;
                stall_left  = (r2 < 5) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_pixel(o_pixel_argb, o_row_end);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles, %0d pixels still due",
                     $time, WATCHDOG_LIMIT, sb.due_pixels.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gap_left != 0) begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            no_gap_left = $urandom_range(20, 150);
            return 0;
        end
        if (light_idle) return (r < 99) ? 0 : $urandom_range(1, 3);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit [7:0] pick_filter();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 88) return 8'($urandom_range(0, 4));
        if (r < 93) return 8'hff;
        return 8'($urandom_range(5, 254));
    endfunction

    function automatic bit [7:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return 8'h00;
        if (r < 16) return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input bit [7:0] raw, input bit start);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_raw_byte    <= raw;
        i_image_start <= start;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_byte(raw, start);
    endtask

    // drain owed pixels, then allow for bytes still in flight that owe nothing
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (sb.due_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input bit [psu_pkg::WIDTH_W-1:0] px_width, input bit alpha);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= psu_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data  <= px_width;
        @(posedge i_clk);
        i_cfg_index <= psu_pkg::CFG_HAS_ALPHA;
        i_cfg_data  <= {{(psu_pkg::WIDTH_W-1){1'b0}}, alpha};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(psu_pkg::CFG_IMAGE_WIDTH, px_width);
        sb.write_reg(psu_pkg::CFG_HAS_ALPHA, {{(psu_pkg::WIDTH_W-1){1'b0}}, alpha});
        sb.n_settings++;
    endtask

    // mostly whole rows; a later row that would read unwritten store entries opens a new image
    task automatic run_phase(input int unsigned n_bytes);
        int unsigned sent;
        bit [7:0]    raw;
        bit          start;
        sent = 0;
        while (sent < n_bytes || !sb.awaiting_filter) begin
            if (sb.awaiting_filter) begin
                start = (!sb.first_row && sb.row_bytes() > sb.store_extent)
                        || $urandom_range(0, 19) == 0;
                raw   = pick_filter();
            end else begin
                if (sb.first_row && $urandom_range(0, 99) == 0)
                    configure(psu_pkg::WIDTH_W'($urandom_range(0, 8)),
                              1'($urandom_range(0, 1)));
                start = ($urandom_range(0, 149) == 0);
                raw   = start ? pick_filter() : pick_sample();
            end
            send_byte(raw, start);
            sent++;
        end
    endtask

    // start of a first row at the widest setting, then above the maximum
    task automatic run_widest_row();
        light_idle = 1'b1;
        configure(psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH), 1'b1);
        send_byte(8'($urandom_range(0, 4)), 1'b1);
        for (int unsigned i = 0; i < WIDE_SAMPLES; i++) begin
            if (i == WIDE_SAMPLES / 2) configure('1, 1'b1);
            send_byte(pick_sample(), 1'b0);
        end
        light_idle = 1'b0;
    endtask

    initial begin
        sb = new;
        sb.clear();
        light_idle  = 1'b0;
        no_gap_left = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        configure(15'd1, 1'b0);
        for (int i = 0; i < 24; i++)
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);

        for (int i = 0; i < 11; i++) begin
            if (i == 5) run_widest_row();
            configure(psu_pkg::WIDTH_W'(phase_width[i]),
                      (i < 2) ? i[0] : 1'($urandom_range(0, 1)));
            run_phase(PHASE_BYTES);
        end

        quiesce();
        repeat (8) @(posedge i_clk);
        $display("run covered %0d requests and %0d pixels (%0d row ends) over %0d settings",
                 sb.n_requests, sb.n_pixels, sb.n_row_ends, sb.n_settings);
        $display("filter bytes: none %0d sub %0d up %0d average %0d paeth %0d unknown %0d",
                 sb.filter_count[0], sb.filter_count[1], sb.filter_count[2],
                 sb.filter_count[3], sb.filter_count[4], sb.filter_count[5]);
        if (sb.n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", sb.n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/psu_pkg.sv
hw/rtl/psu_line_store.sv
hw/rtl/psu_ctrl.sv
hw/rtl/psu_recon.sv
hw/rtl/psu_out_fifo.sv
hw/rtl/png_scanline_unfilter.sv
hw/rtl/psu_checker.sv
bench/tb_png_scanline_unfilter.sv
